/* src/tkd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types and constants of the top-k distinct score tracker.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int SCORE_W      = 32;
  localparam int WANT_W       = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int DEF_MAX_KEEP = 16;

  localparam logic [WANT_W-1:0]  WANTED_RESET = WANT_W'(16);
  localparam logic [SCORE_W-1:0] MIN_RESET    = '0;
  localparam logic [SCORE_W-1:0] SCORE_MAX    = {1'b0, {(SCORE_W-1){1'b1}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WANTED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 1'd1;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLOOR,
    ST_READ
  } state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;
    logic rd_shift;
  } cell_ctrl_t;

endpackage

/* src/tkd_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_cell
// One slot of the sorted score chain: compares, inserts and shifts.
// ----------------------------------------------------------------------------
module tkd_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                        clk,
  input  tkd_pkg::cell_ctrl_t         ctrl,
  input  logic [tkd_pkg::SCORE_W-1:0] score_in,
  input  logic [CNT_W-1:0]            kept,
  input  logic [tkd_pkg::SCORE_W-1:0] left_score,
  input  logic                        left_gt,
  input  logic [tkd_pkg::SCORE_W-1:0] right_score,
  output logic [tkd_pkg::SCORE_W-1:0] score_o,
  output logic                        gt_o,
  output logic                        eq_o
);

  logic [tkd_pkg::SCORE_W-1:0] score_r;
  logic                        occ;

  assign occ     = kept > CNT_W'(IDX);
  assign gt_o    = occ && ($signed(score_r) > $signed(score_in));
  assign eq_o    = occ && (score_r == score_in);
  assign score_o = score_r;

  // greater cells stay put; the first smaller one takes the new score,
  // the rest take their left neighbour
  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (!gt_o) begin
        score_r <= left_gt ? score_in : left_score;
      end
    end else if (ctrl.rd_shift) begin
      score_r <= right_score;
    end
  end

endmodule

/* src/top_k_distinct_score_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_distinct_score_tracker
// Keeps the best distinct scores of a stream in a sorted chain of cells.
// ----------------------------------------------------------------------------
// Input channel in_*: one score per transfer, or an end-of-stream marker.
// Output channel out_*: one status result per score, or the list readout,
// best entry first, with last_of_run on the final result of an input.
// Config port cfg_*: wanted_count (index 0) and min_score (index 1), to be
// written by the user only while the block is idle, which the block does not
// enforce; min_score is loaded at reset and at each end-of-stream clear.
// A score is inserted by all cells in parallel on the accept edge; the floor
// is then checked against the tail cell in ST_FLOOR, and the status result is
// registered once the output register is free; the next score waits for ST_IDLE.
// An end-of-stream marker gives one entry result per kept entry (at least one),
// the chain shifting towards cell 0 as entries go out.
// Reset empties the list and loads the register reset values; no clearing
// pass is needed. A stalled receiver holds the output register; a score
// may still be accepted then, and the block waits before writing its result.
// ----------------------------------------------------------------------------
module top_k_distinct_score_tracker #(
  parameter int MAX_KEEP = tkd_pkg::DEF_MAX_KEEP,
  parameter int CNT_W    = $clog2(MAX_KEEP + 1),
  parameter int RANK_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [tkd_pkg::SCORE_W-1:0] in_score,
  input  logic                          in_end_of_stream,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_result_kind,
  output logic [CNT_W-1:0]              out_found_count,
  output logic signed [tkd_pkg::SCORE_W-1:0] out_score_floor,
  output logic                          out_floor_changed,
  output logic [RANK_W-1:0]             out_rank,
  output logic signed [tkd_pkg::SCORE_W-1:0] out_entry_score,
  output logic                          out_entry_valid,
  output logic                          out_last_of_run,

  input  logic                          cfg_wr_en,
  input  logic [tkd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tkd_pkg::SCORE_W-1:0]   cfg_data
);

  localparam int SW    = tkd_pkg::SCORE_W;
  localparam int LIM_W = (CNT_W > tkd_pkg::WANT_W) ? CNT_W : tkd_pkg::WANT_W;

  // configuration
  logic [tkd_pkg::WANT_W-1:0] wanted_r;
  logic [SW-1:0]              min_score_r;

  // tracker state
  tkd_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  kept_r, kept_nxt;
  logic [SW-1:0]     min_r;
  logic [SW-1:0]     floor_r;
  logic [CNT_W-1:0]  rd_total_r;
  logic [RANK_W-1:0] rd_idx_r;
  logic              ins_r;

  // output register
  logic              out_valid_r;
  logic              out_kind_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [SW-1:0]     out_floor_r;
  logic              out_changed_r;
  logic [RANK_W-1:0] out_rank_r;
  logic [SW-1:0]     out_entry_r;
  logic              out_evalid_r;
  logic              out_last_r;

  // cell chain
  tkd_pkg::cell_ctrl_t ctrl;
  logic [SW-1:0]       cell_score [MAX_KEEP];
  logic [MAX_KEEP-1:0] cell_gt;
  logic [MAX_KEEP-1:0] cell_eq;
  logic [MAX_KEEP-1:0] tail_sel;

  logic [LIM_W-1:0] want_ext;
  logic [LIM_W-1:0] lim_cnt;
  logic [CNT_W-1:0] eff_n;
  logic [CNT_W-1:0] kc;
  logic             in_acc;
  logic             out_free;
  logic             tail_gt;
  logic             do_insert;
  logic [SW-1:0]    tail_score;
  logic             raise;
  logic [SW-1:0]    new_floor;
  logic             emit_status;
  logic             emit_entry;
  logic             rd_empty;
  logic             rd_last;
  logic [CNT_W-1:0] rd_next_cnt;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // effective count: zero acts as one, clamp at the chain length
  assign want_ext = LIM_W'(wanted_r);
  always_comb begin
    if (want_ext == '0) begin
      lim_cnt = LIM_W'(1);
    end else if (want_ext > LIM_W'(MAX_KEEP)) begin
      lim_cnt = LIM_W'(MAX_KEEP);
    end else begin
      lim_cnt = want_ext;
    end
  end
  assign eff_n = lim_cnt[CNT_W-1:0];
  assign kc    = (kept_r > eff_n) ? eff_n : kept_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
      logic [SW-1:0] left_s;
      logic          left_g;
      logic [SW-1:0] right_s;
      if (gi == 0) begin : g_first
        assign left_s = in_score;
        assign left_g = 1'b1;
      end else begin : g_mid
        assign left_s = cell_score[gi-1];
        assign left_g = cell_gt[gi-1];
      end
      if (gi == MAX_KEEP - 1) begin : g_last
        assign right_s = cell_score[gi];
      end else begin : g_inner
        assign right_s = cell_score[gi+1];
      end
      assign tail_sel[gi] = (eff_n == CNT_W'(gi + 1));

      tkd_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .score_in    (in_score),
        .kept        (kc),
        .left_score  (left_s),
        .left_gt     (left_g),
        .right_score (right_s),
        .score_o     (cell_score[gi]),
        .gt_o        (cell_gt[gi]),
        .eq_o        (cell_eq[gi])
      );
    end
  endgenerate

  // tail slot of the wanted count
  always_comb begin
    tail_score = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      tail_score = tail_score | (cell_score[i] & {SW{tail_sel[i]}});
    end
  end
  assign tail_gt   = |(cell_gt & tail_sel);
  assign do_insert = !(|cell_eq) && !((kc == eff_n) && tail_gt);

  // the floor is only raised after a score that was actually inserted
  assign raise     = ins_r && (kept_r == eff_n)
                     && ($signed(tail_score) > $signed(min_r));
  assign new_floor = (tail_score == tkd_pkg::SCORE_MAX) ? tail_score
                                                        : tail_score + SW'(1);

  assign rd_empty    = (rd_total_r == '0);
  assign rd_next_cnt = CNT_W'(rd_idx_r) + CNT_W'(1);
  assign rd_last     = rd_empty || (rd_next_cnt == rd_total_r);

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    emit_status = 1'b0;
    emit_entry  = 1'b0;
    kept_nxt    = kept_r;
    case (state_r)
      tkd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (in_end_of_stream) begin
            state_nxt = tkd_pkg::ST_READ;
            kept_nxt  = kc;
          end else begin
            state_nxt = tkd_pkg::ST_FLOOR;
            if (do_insert && (kc != eff_n)) begin
              kept_nxt = kc + CNT_W'(1);
            end else begin
              kept_nxt = kc;
            end
          end
        end
      end
      tkd_pkg::ST_FLOOR: begin
        if (out_free) begin
          emit_status = 1'b1;
          state_nxt   = tkd_pkg::ST_IDLE;
        end
      end
      tkd_pkg::ST_READ: begin
        if (out_free) begin
          emit_entry = 1'b1;
          if (rd_last) begin
            state_nxt = tkd_pkg::ST_IDLE;
            kept_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = tkd_pkg::ST_IDLE;
      end
    endcase
  end

  assign ctrl.ins_en   = in_acc && !in_end_of_stream && do_insert;
  assign ctrl.rd_shift = emit_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r    <= tkd_pkg::WANTED_RESET;
      min_score_r <= tkd_pkg::MIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tkd_pkg::REG_WANTED: wanted_r    <= cfg_data[tkd_pkg::WANT_W-1:0];
        tkd_pkg::REG_MIN:    min_score_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r   <= '0;
      min_r    <= tkd_pkg::MIN_RESET;
      floor_r  <= tkd_pkg::MIN_RESET;
      rd_idx_r <= '0;
      ins_r    <= 1'b0;
    end else begin
      kept_r <= kept_nxt;
      if (in_acc) begin
        rd_idx_r <= '0;
        ins_r    <= ctrl.ins_en;
      end else if (emit_entry) begin
        rd_idx_r <= rd_idx_r + RANK_W'(1);
      end
      if (emit_status && raise) begin
        min_r   <= tail_score;
        floor_r <= new_floor;
      end else if (emit_entry && rd_last) begin
        min_r   <= min_score_r;
        floor_r <= min_score_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_total_r <= kc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_status || emit_entry) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_status) begin
      out_kind_r    <= tkd_pkg::KIND_STATUS;
      out_count_r   <= kept_r;
      out_floor_r   <= raise ? new_floor : floor_r;
      out_changed_r <= raise;
      out_rank_r    <= '0;
      out_entry_r   <= '0;
      out_evalid_r  <= 1'b0;
      out_last_r    <= 1'b1;
    end else if (emit_entry) begin
      out_kind_r    <= tkd_pkg::KIND_ENTRY;
      out_count_r   <= rd_total_r;
      out_floor_r   <= floor_r;
      out_changed_r <= 1'b0;
      out_rank_r    <= rd_idx_r;
      out_entry_r   <= rd_empty ? '0 : cell_score[0];
      out_evalid_r  <= !rd_empty;
      out_last_r    <= rd_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_found_count   = out_count_r;
  assign out_score_floor   = out_floor_r;
  assign out_floor_changed = out_changed_r;
  assign out_rank          = out_rank_r;
  assign out_entry_score   = out_entry_r;
  assign out_entry_valid   = out_evalid_r;
  assign out_last_of_run   = out_last_r;

  // checks
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= CNT_W'(MAX_KEEP))
    else $error("kept count beyond chain length");

  a_score_to_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_end_of_stream) |=> (state_r == tkd_pkg::ST_FLOOR))
    else $error("score transfer did not enter floor check");

  a_readout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_entry && rd_last) |=> (kept_r == '0) && (floor_r == min_r)
                                && (state_r == tkd_pkg::ST_IDLE))
    else $error("list not cleared after readout");

  a_changed_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_changed_r) |-> (out_kind_r == tkd_pkg::KIND_STATUS)
                                        && out_last_r)
    else $error("floor change flagged outside a status result");

endmodule
